### hw/rtl/ptfg_pkg.sv
// shared types and constants for the quadratic field gather unit
// request/result payloads, queue entry layout, grid and stagger codes
// no dependencies
package ptfg_pkg;

  localparam int NUM_GRIDS   = 9;
  localparam int NUM_LANES   = 6;
  localparam int QUEUE_DEPTH = 2;

  // request kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_GATHER = 1'b1;

  // configuration register indexes
  localparam logic CFG_INV_CELL_WIDTH  = 1'b0;
  localparam logic CFG_INV_CELL_HEIGHT = 1'b1;

  // stagger codes: msb set means half-cell offset in x, lsb in y
  localparam logic [1:0] STG_WW = 2'd0;
  localparam logic [1:0] STG_WH = 2'd1;
  localparam logic [1:0] STG_HW = 2'd2;
  localparam logic [1:0] STG_HH = 2'd3;

  // grid order: ex, ey, ez, hx, hy, hz, old hx, old hy, old hz
  localparam logic [1:0] GRID_STAGGER [NUM_GRIDS] = '{
    STG_WH, STG_HW, STG_HH, STG_HW, STG_WH, STG_WW, STG_HW, STG_WH, STG_WW
  };

  typedef logic signed [33:0] base_t;
  typedef logic [2:0][15:0]   wset_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         component;
    logic [7:0]         col_index;
    logic [7:0]         row_index;
    logic signed [31:0] field_value;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
  } ptfg_req_t;

  typedef struct packed {
    logic signed [31:0] ex_out;
    logic signed [31:0] ey_out;
    logic signed [31:0] ez_out;
    logic signed [31:0] hx_out;
    logic signed [31:0] hy_out;
    logic signed [31:0] hz_out;
    logic               off_grid;
  } ptfg_result_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         component;
    logic [7:0]         col_index;
    logic [7:0]         row_index;
    logic signed [31:0] field_value;
    base_t              bxw;
    base_t              bxh;
    base_t              byw;
    base_t              byh;
    wset_t              wxw;
    wset_t              wxh;
    wset_t              wyw;
    wset_t              wyh;
  } ptfg_entry_t;

  typedef struct packed {
    logic        push;
    ptfg_entry_t entry;
  } ptfg_push_t;

endpackage

### hw/rtl/ptfg_ram.sv
// generic single-port ram with registered read
// no dependencies
module ptfg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/ptfg_front.sv
// front end: accepts requests, holds config, scales position and builds weights
// depends on ptfg_pkg
module ptfg_front import ptfg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  ptfg_req_t  req,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [31:0] cfg_data,
  output ptfg_push_t qpush,
  input  logic       full
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_WGT, S_PUSH} state_t;
  typedef enum logic [1:0] {AX_XW, AX_XH, AX_YW, AX_YH} axis_t;

  state_t      state;
  axis_t       ax;
  logic [31:0] inv_w;
  logic [31:0] inv_h;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [63:0] ux;
  logic [63:0] uy;
  ptfg_entry_t ent;

  logic [63:0]        u;
  logic [65:0]        v;
  base_t              base;
  logic [31:0]        frac;
  logic [15:0]        f;
  logic [16:0]        a;
  logic [33:0]        aa;
  logic signed [16:0] xs;
  logic signed [33:0] xx;
  logic [15:0]        w1;
  logic [15:0]        w2;
  logic [15:0]        w3;

  // one axis variant per cycle
  always_comb begin
    u = (ax == AX_YW || ax == AX_YH) ? uy : ux;
    v = {2'b00, u} - 66'h0_8000_0000;
    if (ax == AX_XW || ax == AX_YW) begin
      base = base_t'(v[65:32]);
      frac = v[31:0];
    end else begin
      base = base_t'({2'b00, u[63:32]});
      frac = u[31:0];
    end
    f  = frac[31:16];
    a  = 17'h10000 - {1'b0, f};
    aa = 34'(a) * 34'(a);
    xs = $signed({1'b0, f}) - 17'sd32768;
    xx = 34'(xs) * 34'(xs);
    w1 = 16'(aa >> 17);
    w2 = 16'(17'd49152 - 17'(xx >>> 16));
    w3 = 16'(17'h10000 - {1'b0, w1} - {1'b0, w2});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ax    <= AX_XW;
      inv_w <= 32'h0001_0000;
      inv_h <= 32'h0001_0000;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_INV_CELL_WIDTH:  inv_w <= cfg_data;
          CFG_INV_CELL_HEIGHT: inv_h <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            ent.kind        <= req.kind;
            ent.component   <= req.component;
            ent.col_index   <= req.col_index;
            ent.row_index   <= req.row_index;
            ent.field_value <= req.field_value;
            pos_x           <= req.pos_x;
            pos_y           <= req.pos_y;
            state <= (req.kind == KIND_GATHER) ? S_MUL : S_PUSH;
          end
        end
        S_MUL: begin
          ux    <= 64'(pos_x) * 64'(inv_w);
          uy    <= 64'(pos_y) * 64'(inv_h);
          ax    <= AX_XW;
          state <= S_WGT;
        end
        S_WGT: begin
          unique case (ax)
            AX_XW: begin ent.bxw <= base; ent.wxw <= {w3, w2, w1}; end
            AX_XH: begin ent.bxh <= base; ent.wxh <= {w3, w2, w1}; end
            AX_YW: begin ent.byw <= base; ent.wyw <= {w3, w2, w1}; end
            AX_YH: begin ent.byh <= base; ent.wyh <= {w3, w2, w1}; end
            default: ;
          endcase
          if (ax == AX_YH) begin
            state <= S_PUSH;
          end else begin
            ax <= axis_t'(ax + 2'd1);
          end
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign qpush.push  = (state == S_PUSH) && !full;
  assign qpush.entry = ent;

endmodule

### hw/rtl/ptfg_queue.sv
// short request queue between front end and back end
// depends on ptfg_pkg
module ptfg_queue import ptfg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ptfg_push_t  qpush,
  input  logic        pop,
  output ptfg_entry_t head,
  output logic        empty,
  output logic        full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  ptfg_entry_t   slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  always_ff @(posedge clk) begin
    if (qpush.push) begin
      slots[wptr] <= qpush.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (qpush.push) begin
        wptr <= (wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (PW+1)'(qpush.push) - (PW+1)'(pop);
    end
  end

  assign head  = slots[rptr];
  assign empty = (count == '0);
  assign full  = (count == (PW+1)'(QUEUE_DEPTH));

endmodule

### hw/rtl/ptfg_back.sv
// back end: grid memories, stencil read sequencer and interpolation pipeline
// depends on ptfg_pkg and ptfg_ram
module ptfg_back import ptfg_pkg::*; #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  ptfg_entry_t  head,
  input  logic         empty,
  output logic         pop,
  output logic         done,
  output ptfg_result_t result
);

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_COLS);
  localparam int RW    = $clog2(GRID_ROWS);

  typedef struct packed {
    logic        vld;
    logic [1:0]  i;
    logic [1:0]  j;
    logic [3:0]  in_mask;
    logic [15:0] wy_w;
    logic [15:0] wy_h;
    logic [15:0] wx_w;
    logic [15:0] wx_h;
    logic        off;
  } tag1_t;

  typedef struct packed {
    logic        vld;
    logic        first_j;
    logic        last_j;
    logic        first_i;
    logic        last;
    logic [15:0] wx_w;
    logic [15:0] wx_h;
    logic        off;
  } tag2_t;

  typedef struct packed {
    logic        vld;
    logic        first_i;
    logic        last;
    logic [15:0] wx_w;
    logic [15:0] wx_h;
    logic        off;
  } tag3_t;

  typedef struct packed {
    logic vld;
    logic first_i;
    logic last;
    logic off;
  } tag4_t;

  logic [1:0] i;
  logic [1:0] j;
  logic       off_run;
  tag1_t      t1;
  tag2_t      t2;
  tag3_t      t3;
  tag4_t      t4;

  logic    is_load;
  logic    is_gat;
  logic    ld_ok;
  logic    last_pt;
  logic    off_all;
  base_t   col_w, col_h, row_w, row_h;
  logic    in_cw, in_ch, in_rw, in_rh;
  logic [3:0]    in_c;
  logic [AW-1:0] addr_c [4];
  logic [AW-1:0] ld_addr;
  logic [31:0]   rd [NUM_GRIDS];

  logic signed [49:0] p2    [NUM_LANES];
  logic signed [51:0] csum  [NUM_LANES];
  logic signed [51:0] cs3   [NUM_LANES];
  logic signed [52:0] m4    [NUM_LANES];
  logic signed [54:0] acc   [NUM_LANES];
  logic signed [49:0] prod  [NUM_LANES];
  logic signed [51:0] csum_next [NUM_LANES];
  logic signed [52:0] mul3  [NUM_LANES];
  logic signed [54:0] acc_next  [NUM_LANES];
  logic signed [31:0] fin   [NUM_LANES];

  function automatic logic inside_col(input base_t c);
    return !c[33] && (c < base_t'(GRID_COLS));
  endfunction

  function automatic logic inside_row(input base_t r);
    return !r[33] && (r < base_t'(GRID_ROWS));
  endfunction

  function automatic logic [AW-1:0] grid_addr(input base_t c, input base_t r);
    return AW'(AW'(r[RW-1:0]) * AW'(GRID_COLS)) + AW'(c[CW-1:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [54:0] s);
    logic signed [31:0] r;
    if (s > 55'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (s < -55'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(s);
    end
    return r;
  endfunction

  // stencil point addresses for the four stagger combinations
  always_comb begin
    is_load = !empty && (head.kind == KIND_LOAD);
    is_gat  = !empty && (head.kind == KIND_GATHER);
    last_pt = (i == 2'd2) && (j == 2'd2);
    pop     = is_load || (is_gat && last_pt);
    col_w = head.bxw + base_t'(i) - base_t'(1);
    col_h = head.bxh + base_t'(i) - base_t'(1);
    row_w = head.byw + base_t'(j) - base_t'(1);
    row_h = head.byh + base_t'(j) - base_t'(1);
    in_cw = inside_col(col_w);
    in_ch = inside_col(col_h);
    in_rw = inside_row(row_w);
    in_rh = inside_row(row_h);
    in_c[STG_WW] = in_cw && in_rw;
    in_c[STG_WH] = in_cw && in_rh;
    in_c[STG_HW] = in_ch && in_rw;
    in_c[STG_HH] = in_ch && in_rh;
    addr_c[STG_WW] = grid_addr(col_w, row_w);
    addr_c[STG_WH] = grid_addr(col_w, row_h);
    addr_c[STG_HW] = grid_addr(col_h, row_w);
    addr_c[STG_HH] = grid_addr(col_h, row_h);
    off_all = ((i == 2'd0) && (j == 2'd0) ? 1'b0 : off_run) | ~(&in_c);
    ld_addr = AW'(AW'(head.row_index) * AW'(GRID_COLS)) + AW'(head.col_index);
    ld_ok   = (head.component < 4'(NUM_GRIDS))
           && (32'(head.col_index) < 32'(GRID_COLS))
           && (32'(head.row_index) < 32'(GRID_ROWS));
  end

  for (genvar g = 0; g < NUM_GRIDS; g++) begin : g_grid
    ptfg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (is_load && ld_ok && (head.component == 4'(g))),
      .addr  (is_load ? ld_addr : addr_c[GRID_STAGGER[g]]),
      .wdata (head.field_value),
      .rdata (rd[g])
    );
  end

  // per-lane arithmetic: ex, ey, ez, hx, hy, hz
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    localparam logic [1:0] STG = GRID_STAGGER[l];
    logic signed [32:0] val;
    logic [15:0]        wy;
    logic [15:0]        wx2;
    logic [15:0]        wx3;

    if (l < 3) begin : g_e
      assign val = t1.in_mask[STG] ? 33'($signed(rd[l])) : '0;
    end else begin : g_h
      assign val = t1.in_mask[STG] ? 33'($signed(rd[l])) + 33'($signed(rd[l+3])) : '0;
    end

    assign wy  = STG[0] ? t1.wy_h : t1.wy_w;
    assign wx3 = STG[1] ? t3.wx_h : t3.wx_w;
    assign wx2 = wx3;

    always_comb begin
      prod[l]      = 50'(val) * 50'($signed({1'b0, wy}));
      csum_next[l] = (t2.first_j ? 52'sd0 : csum[l]) + 52'(p2[l]);
      mul3[l]      = 53'(cs3[l] >>> 16) * 53'($signed({1'b0, wx2}));
      acc_next[l]  = (t4.first_i ? 55'sd0 : acc[l]) + 55'(m4[l]);
      fin[l]       = (l < 3) ? sat32(acc_next[l] >>> 16) : sat32(acc_next[l] >>> 17);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i       <= '0;
      j       <= '0;
      t1.vld  <= 1'b0;
      t2.vld  <= 1'b0;
      t3.vld  <= 1'b0;
      t4.vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      if (is_gat) begin
        off_run <= off_all;
        if (j == 2'd2) begin
          j <= '0;
          i <= (i == 2'd2) ? 2'd0 : i + 2'd1;
        end else begin
          j <= j + 2'd1;
        end
      end
      t1.vld     <= is_gat;
      t1.i       <= i;
      t1.j       <= j;
      t1.in_mask <= in_c;
      t1.wy_w    <= head.wyw[j];
      t1.wy_h    <= head.wyh[j];
      t1.wx_w    <= head.wxw[i];
      t1.wx_h    <= head.wxh[i];
      t1.off     <= off_all;

      t2.vld     <= t1.vld;
      t2.first_j <= (t1.j == 2'd0);
      t2.last_j  <= (t1.j == 2'd2);
      t2.first_i <= (t1.i == 2'd0);
      t2.last    <= (t1.i == 2'd2) && (t1.j == 2'd2);
      t2.wx_w    <= t1.wx_w;
      t2.wx_h    <= t1.wx_h;
      t2.off     <= t1.off;

      t3.vld     <= t2.vld && t2.last_j;
      t3.first_i <= t2.first_i;
      t3.last    <= t2.last;
      t3.wx_w    <= t2.wx_w;
      t3.wx_h    <= t2.wx_h;
      t3.off     <= t2.off;

      t4.vld     <= t3.vld;
      t4.first_i <= t3.first_i;
      t4.last    <= t3.last;
      t4.off     <= t3.off;

      done <= t4.vld && t4.last;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < NUM_LANES; l++) begin
      p2[l] <= prod[l];
      if (t2.vld) begin
        csum[l] <= csum_next[l];
      end
      if (t2.vld && t2.last_j) begin
        cs3[l] <= csum_next[l];
      end
      m4[l] <= mul3[l];
      if (t4.vld) begin
        acc[l] <= acc_next[l];
      end
    end
    if (t4.vld && t4.last) begin
      result.ex_out   <= fin[0];
      result.ey_out   <= fin[1];
      result.ez_out   <= fin[2];
      result.hx_out   <= fin[3];
      result.hy_out   <= fin[4];
      result.hz_out   <= fin[5];
      result.off_grid <= t4.off;
    end
  end

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held for two cycles");

  a_gather_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_GATHER) |-> (i == 2'd2 && j == 2'd2))
    else $error("gather request released before all stencil points were read");

  a_last_to_done: assert property (@(posedge clk) disable iff (rst)
    (t1.vld && t1.i == 2'd2 && t1.j == 2'd2) |-> ##4 done)
    else $error("last stencil point did not produce a result");

  a_no_write_in_gather: assert property (@(posedge clk) disable iff (rst)
    (t1.vld && !(t1.i == 2'd2 && t1.j == 2'd2)) |-> !is_load)
    else $error("grid write interleaved with a gather");

endmodule

### hw/rtl/pic_tsc_field_gather_2d_unit.sv
// top level of the quadratic field gather unit
// depends on ptfg_pkg, ptfg_front, ptfg_queue, ptfg_back, ptfg_ram
//
// A request is taken when start is high and busy is low. A load request writes
// one grid word; a gather request keeps busy high while the position is scaled
// and the weights are built. Requests then wait in a two-entry queue for the
// back end, which reads one stencil point per cycle from all nine grid memories
// at once for each gather. A gather result appears on the result port with done
// high for exactly one cycle, once its last read has passed the tag stages t1 to
// t4; the receiver cannot stall it. The back end starts reading the next gather
// while the last one is still in flight. Grid words are undefined until loaded;
// there is no clearing pass after reset, so every word a gather touches must be
// written first.
module pic_tsc_field_gather_2d_unit import ptfg_pkg::*; #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  ptfg_req_t    req,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [31:0]  cfg_data,
  output logic         done,
  output ptfg_result_t result
);

  ptfg_push_t  qpush;
  ptfg_entry_t head;
  logic        empty;
  logic        full;
  logic        pop;

  ptfg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qpush     (qpush),
    .full      (full)
  );

  ptfg_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qpush (qpush),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .full  (full)
  );

  ptfg_back #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (empty),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
